// ===== rtl/core/wme_pkg.sv =====
`default_nettype none
package wme_pkg;

  localparam int unsigned SymCount  = 162;
  localparam int unsigned IlvCount  = 256;
  localparam int unsigned MsgBits   = 50;
  localparam int unsigned CallBits  = 28;
  localparam int unsigned LocBits   = 22;
  localparam int unsigned AddrBits  = $clog2(SymCount);
  localparam int unsigned CharCount = 6;

  localparam logic [31:0] PolyA = 32'h8ACA0B4E;
  localparam logic [31:0] PolyB = 32'hE23C8626;

  localparam logic [7:0] SymLast = 8'(SymCount - 1);

  // sync vector, symbol n at bit n
  localparam logic [167:0] SyncVec = {
    8'h00, 8'h63, 8'h58, 8'h0c, 8'ha0, 8'he2, 8'hcd, 8'hc9, 8'h04, 8'h56, 8'h34,
    8'h95, 8'h58, 8'h58, 8'hb3, 8'h40, 8'ha4, 8'h07, 8'ha4, 8'h71, 8'h03
  };

  localparam logic OpEncode = 1'b0;
  localparam logic OpTone   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PACK,
    ST_RUN,
    ST_READ,
    ST_DONE
  } wme_state_e;

  // callsign symbols, index 0 is the first character
  typedef logic [CharCount-1:0][5:0] wme_call_t;

  typedef struct packed {
    logic                we;
    logic [AddrBits-1:0] waddr;
    logic                wdata;
    logic                re;
    logic [AddrBits-1:0] raddr;
  } wme_mem_req_t;

  // {ok, value}
  function automatic logic [6:0] map_char(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41 + 8'd10)};
    end else if (c == 8'h20) begin
      r = {1'b1, 6'd36};
    end
    return r;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wme_pack.sv =====
`default_nettype none
module wme_pack
  import wme_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire wme_call_t                  call_i,
  input  wire logic [31:0]                loc_i,
  input  wire logic [6:0]                 pwr_i,
  output logic                            done_o,
  output logic [MsgBits-1:0]              msg_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [2:0]          step_q, step_d;
  wme_call_t           call_q;
  logic [6:0]          pwr_q;
  logic [CallBits-1:0] cw_q, cw_d;
  logic [LocBits-1:0]  lw_q, lw_d;
  logic [LocBits-1:0]  lb_q, lb_d;
  logic [LocBits-1:0]  l0, l1, l2, l3, pwr_ext;

  assign l0 = LocBits'(loc_i[31:24]);
  assign l1 = LocBits'(loc_i[23:16]);
  assign l2 = LocBits'(loc_i[15:8]);
  assign l3 = LocBits'(loc_i[7:0]);
  assign pwr_ext = {{(LocBits-7){pwr_q[6]}}, pwr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    cw_d   = cw_q;
    lw_d   = lw_q;
    lb_d   = lb_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = 3'd1;
      cw_d   = CallBits'(call_i[0]);
      lw_d   = LocBits'(179) - LocBits'(10) * (l0 - LocBits'(65)) - (l2 - LocBits'(48));
      lb_d   = LocBits'(10) * (l1 - LocBits'(65)) + (l3 - LocBits'(48));
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      case (step_q)
        3'd1: begin
          cw_d = cw_q * CallBits'(36) + CallBits'(call_q[1]);
          lw_d = lw_q * LocBits'(180) + lb_q;
        end
        3'd2: begin
          cw_d = cw_q * CallBits'(10) + CallBits'(call_q[2]);
          lw_d = {lw_q[LocBits-8:0], 7'd0} + pwr_ext + LocBits'(64);
        end
        3'd3: cw_d = cw_q * CallBits'(27) + CallBits'(call_q[3]) - CallBits'(10);
        3'd4: cw_d = cw_q * CallBits'(27) + CallBits'(call_q[4]) - CallBits'(10);
        3'd5: begin
          cw_d   = cw_q * CallBits'(27) + CallBits'(call_q[5]) - CallBits'(10);
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q <= cw_d;
    lw_q <= lw_d;
    lb_q <= lb_d;
    if (start_i) begin
      call_q <= call_i;
      pwr_q  <= pwr_i;
    end
  end

  assign done_o = done_q;
  assign msg_o  = {cw_q, lw_q};

endmodule
`default_nettype wire

// ===== rtl/core/wme_conv.sv =====
`default_nettype none
module wme_conv
  import wme_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               load_i,
  input  wire logic [MsgBits-1:0] msg_i,
  input  wire logic               step_i,
  output logic                    a_bit_o,
  output logic                    b_bit_o
);

  logic [MsgBits-1:0] msg_q;
  logic [31:0]        ra_q, rb_q, ra_n, rb_n;
  logic               din;

  // Galois form: data enters at the LSB, parity taken at the MSB
  assign din  = msg_q[MsgBits-1];
  assign ra_n = {ra_q[30:0], din} ^ (din ? PolyA : 32'd0);
  assign rb_n = {rb_q[30:0], din} ^ (din ? PolyB : 32'd0);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      msg_q <= msg_i;
      ra_q  <= 32'd0;
      rb_q  <= 32'd0;
    end else if (step_i) begin
      msg_q <= {msg_q[MsgBits-2:0], 1'b0};
      ra_q  <= ra_n;
      rb_q  <= rb_n;
    end
  end

  assign a_bit_o = ra_n[31];
  assign b_bit_o = rb_q[31];

endmodule
`default_nettype wire

// ===== rtl/core/wme_store.sv =====
`default_nettype none
module wme_store
  import wme_pkg::*;
(
  input  wire logic         clk_i,
  input  wire wme_mem_req_t req_i,
  output logic              rdata_o
);

  logic mem_q [SymCount];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/wspr_message_encoder.sv =====
`default_nettype none
// WSPR Type 1 message encoder with a 162-symbol channel store.
// Input stream: s_axis_tuser_i selects the operation (0 = encode, 1 = tone read).
//   An encode transfer packs callsign, locator and power into 50 bits, runs them
//   with 31 tail zeros through the rate-1/2 K=32 convolutional coder and writes
//   the interleaved 162 channel bits into the symbol memory.
//   A tone read returns sync bit + 2 * stored bit for one symbol index.
// Output stream: one transfer per input transfer, tone in [1:0], reject flag in [2].
// Processing (a new input is taken only in the idle state):
//   tone read: the memory read data, result and output registers lie between the
//   input transfer and the result. encode: 6 packing steps, then the 256-entry
//   bit-reversal interleave walk, one position per cycle, one memory write per hit.
//   rejected callsign: the result goes straight to DONE, memory untouched.
// Reset: control returns to idle and the memory reads as all zeros until the
//   first encode completes, since an encode that is not rejected writes all 162 entries.
// A stalled receiver holds the result in the output register; the block keeps
//   working on the next item and waits only when a second result is ready.
module wspr_message_encoder
  import wme_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [47:0] call_chars, [79:48] locator_chars, [86:80] power_dbm,
  // [94:87] symbol_index, [95] zero
  input  wire logic [95:0] s_axis_tdata_i,
  // [0] opcode
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [1:0] tone, [2] call_rejected, [7:3] zero
  output logic [7:0]       m_axis_tdata_o
);

  wme_state_e state_q, state_d;

  logic [7:0]          cnt_q, cnt_d;        // interleave position
  logic                half_q, half_d;      // second parity bit of a stage pending
  logic                filled_q, filled_d;  // store written at least once
  logic [AddrBits-1:0] idx_q, idx_d;
  logic [1:0]          res_tone_q, res_tone_d;
  logic                res_rej_q, res_rej_d;
  logic                out_vld_q, out_vld_d;
  logic [1:0]          out_tone_q, out_tone_d;
  logic                out_rej_q, out_rej_d;

  logic               in_xfer;
  logic [47:0]        call_chars;
  logic [31:0]        loc_chars;
  logic [6:0]         pwr;
  logic [7:0]         sym_idx;
  wme_call_t          call_map;
  logic               call_ok;
  logic [6:0]         mc [CharCount];

  logic               pack_start, pack_done;
  logic [MsgBits-1:0] msg;
  logic               conv_load, conv_step, a_bit, b_bit;
  wme_mem_req_t       mem_req;
  logic               rdata;
  logic [7:0]         ilv_addr;
  logic               ilv_hit;

  assign call_chars = s_axis_tdata_i[47:0];
  assign loc_chars  = s_axis_tdata_i[79:48];
  assign pwr        = s_axis_tdata_i[86:80];
  assign sym_idx    = s_axis_tdata_i[94:87];

  // first character sits in the top byte
  always_comb begin
    call_ok = 1'b1;
    for (int k = 0; k < CharCount; k++) begin
      mc[k]       = map_char(call_chars[8*(CharCount-1-k) +: 8]);
      call_map[k] = mc[k][5:0];
      call_ok     = call_ok & mc[k][6];
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;

  assign ilv_addr = rev8(cnt_q);
  assign ilv_hit  = (ilv_addr <= SymLast);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    half_d     = half_q;
    filled_d   = filled_q;
    idx_d      = idx_q;
    res_tone_d = res_tone_q;
    res_rej_d  = res_rej_q;
    out_vld_d  = out_vld_q;
    out_tone_d = out_tone_q;
    out_rej_d  = out_rej_q;
    pack_start = 1'b0;
    conv_load  = 1'b0;
    conv_step  = 1'b0;
    mem_req    = '0;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          res_tone_d = 2'd0;
          res_rej_d  = 1'b0;
          if (s_axis_tuser_i == OpTone) begin
            idx_d         = sym_idx;
            mem_req.re    = (sym_idx <= SymLast);
            mem_req.raddr = sym_idx;
            state_d       = ST_READ;
          end else if (!call_ok) begin
            res_rej_d = 1'b1;
            state_d   = ST_DONE;
          end else begin
            pack_start = 1'b1;
            state_d    = ST_PACK;
          end
        end
      end
      ST_PACK: begin
        if (pack_done) begin
          conv_load = 1'b1;
          cnt_d     = 8'd0;
          half_d    = 1'b0;
          state_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ilv_hit) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ilv_addr;
          mem_req.wdata = half_q ? b_bit : a_bit;
          conv_step     = ~half_q;
          half_d        = ~half_q;
        end
        cnt_d = cnt_q + 8'd1;
        if (cnt_q == 8'(IlvCount - 1)) begin
          filled_d = 1'b1;
          state_d  = ST_DONE;
        end
      end
      ST_READ: begin
        if (idx_q <= SymLast) begin
          res_tone_d = {rdata & filled_q, SyncVec[idx_q]};
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_tone_d = res_tone_q;
          out_rej_d  = res_rej_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      filled_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      filled_q  <= filled_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    half_q     <= half_d;
    idx_q      <= idx_d;
    res_tone_q <= res_tone_d;
    res_rej_q  <= res_rej_d;
    out_tone_q <= out_tone_d;
    out_rej_q  <= out_rej_d;
  end

  wme_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pack_start),
    .call_i  (call_map),
    .loc_i   (loc_chars),
    .pwr_i   (pwr),
    .done_o  (pack_done),
    .msg_o   (msg)
  );

  wme_conv u_conv (
    .clk_i   (clk_i),
    .load_i  (conv_load),
    .msg_i   (msg),
    .step_i  (conv_step),
    .a_bit_o (a_bit),
    .b_bit_o (b_bit)
  );

  wme_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, out_rej_q, out_tone_q};

endmodule
`default_nettype wire

// ===== verif/tb_wspr_message_encoder.sv =====
`timescale 1ns / 1ps

module tb_wspr_message_encoder;

  localparam int unsigned NumSymbols = 162;
  localparam int unsigned NumStages  = 81;
  localparam bit [31:0]   ParityA    = 32'h8ACA0B4E;
  localparam bit [31:0]   ParityB    = 32'hE23C8626;
  localparam int unsigned ItemsPerPhase = 175;

  typedef struct packed {
    bit        op;
    bit [47:0] call;
    bit [31:0] loc;
    bit [6:0]  pwr;
    bit [7:0]  idx;
  } wspr_item_t;

  typedef struct packed {
    bit [1:0] tone;
    bit       rejected;
  } tone_result_t;

  // Keeps a private copy of the symbol store and the tones it should produce.
  class tone_scoreboard;
    bit [NumSymbols-1:0] symbol_store;
    tone_result_t        expected_q[$];
    int unsigned         mismatches;
    bit [7:0]            sync_bytes[21];

    function new();
      symbol_store = '0;
      mismatches   = 0;
      sync_bytes   = '{8'h03, 8'h71, 8'ha4, 8'h07, 8'ha4, 8'h40, 8'hb3, 8'h58, 8'h58,
                       8'h95, 8'h34, 8'h56, 8'h04, 8'hc9, 8'hcd, 8'he2, 8'ha0, 8'h0c,
                       8'h58, 8'h63, 8'h00};
    endfunction

    // Returns 1 on a bad callsign byte; the store is left alone then.
    function bit encode_message(bit [47:0] call, bit [31:0] loc, bit [6:0] pwr);
      bit [31:0] m[6];
      bit [31:0] l[4];
      bit [31:0] cw, lw, pw, ra, rb;
      bit [49:0] msg;
      bit [2*NumStages-1:0] chan;
      bit [7:0]  c, ib, j;
      bit        b;
      int        p;
      for (int k = 0; k < 6; k++) begin
        c = call[8*(5-k) +: 8];
        if (c >= 8'h30 && c <= 8'h39) m[k] = 32'(c) - 32'h30;
        else if (c >= 8'h41 && c <= 8'h5A) m[k] = 32'(c) - 32'h41 + 32'd10;
        else if (c == 8'h20) m[k] = 32'd36;
        else return 1'b1;
      end
      for (int k = 0; k < 4; k++) l[k] = 32'(loc[8*(3-k) +: 8]);
      // all word arithmetic wraps at 32 bits
      cw = m[0];
      cw = 32'd36 * cw + m[1];
      cw = 32'd10 * cw + m[2];
      cw = 32'd27 * cw + (m[3] - 32'd10);
      cw = 32'd27 * cw + (m[4] - 32'd10);
      cw = 32'd27 * cw + (m[5] - 32'd10);
      pw = {{25{pwr[6]}}, pwr};
      lw = (32'd179 - 32'd10 * (l[0] - 32'h41) - (l[2] - 32'h30)) * 32'd180
           + 32'd10 * (l[1] - 32'h41) + (l[3] - 32'h30);
      lw = 32'd128 * lw + pw + 32'd64;
      msg = {cw[27:0], lw[21:0]};
      // Galois parity registers: data in at the LSB, parity out at the MSB
      ra = '0;
      rb = '0;
      for (int i = 0; i < NumStages; i++) begin
        b  = (i < 50) ? msg[49-i] : 1'b0;
        ra = {ra[30:0], b};
        rb = {rb[30:0], b};
        if (ra[0]) begin
          ra ^= ParityA;
          rb ^= ParityB;
        end
        chan[2*i]   = ra[31];
        chan[2*i+1] = rb[31];
      end
      // bit-reversal interleave, positions past the store are skipped
      p = 0;
      for (int i = 0; i < 256; i++) begin
        ib = 8'(i);
        j  = {<<{ib}};
        if (j < NumSymbols && p < NumSymbols) begin
          symbol_store[j] = chan[p];
          p++;
        end
      end
      return 1'b0;
    endfunction

    function void accept_item(wspr_item_t it);
      tone_result_t r;
      r = '0;
      if (it.op == wme_pkg::OpEncode) begin
        r.rejected = encode_message(it.call, it.loc, it.pwr);
      end else if (it.idx < NumSymbols) begin
        // sync + 2 * data
        r.tone = {symbol_store[it.idx], sync_bytes[it.idx >> 3][it.idx[2:0]]};
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(bit [7:0] data);
      tone_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tone=%0d rej=%0d", data[1:0], data[2]);
        return;
      end
      e = expected_q.pop_front();
      if (data[1:0] != e.tone || data[2] != e.rejected) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp tone=%0d rej=%0d, got tone=%0d rej=%0d",
                   e.tone, e.rejected, data[1:0], data[2]);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [95:0] in_data = '0;
  logic        in_user = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_data;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  tone_scoreboard sb = new();

  always #4 clk_i = ~clk_i;

  wspr_message_encoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),
    .s_axis_tuser_i (in_user),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data)
  );

  // receiver side: stall at random, check every result transfer
  always @(negedge clk_i) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic bit is_call_char(bit [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h20;
  endfunction

  function automatic bit [7:0] rand_call_char();
    int unsigned v;
    v = $urandom_range(36);
    if (v < 10) return 8'(8'h30 + v);
    if (v < 36) return 8'(8'h41 + v - 10);
    return 8'h20;
  endfunction

  function automatic wspr_item_t tone_item(bit [7:0] idx);
    wspr_item_t it;
    it.op   = wme_pkg::OpTone;
    it.call = {16'($urandom), 32'($urandom)};
    it.loc  = $urandom;
    it.pwr  = 7'($urandom);
    it.idx  = idx;
    return it;
  endfunction

  function automatic wspr_item_t encode_item(bit [47:0] call, bit [31:0] loc, bit [6:0] pwr);
    wspr_item_t it;
    it.op   = wme_pkg::OpEncode;
    it.call = call;
    it.loc  = loc;
    it.pwr  = pwr;
    it.idx  = 8'($urandom);
    return it;
  endfunction

  // random message; bad puts one non-callsign byte at a random position
  function automatic wspr_item_t random_encode(bit bad);
    bit [47:0] call;
    bit [31:0] loc;
    bit [7:0]  c;
    int unsigned pos;
    for (int k = 0; k < 6; k++) call[8*k +: 8] = rand_call_char();
    if (bad) begin
      do c = 8'($urandom_range(255)); while (is_call_char(c));
      pos = $urandom_range(5);
      call[8*pos +: 8] = c;
    end
    if ($urandom_range(1)) begin
      loc = {8'(8'h41 + $urandom_range(17)), 8'(8'h41 + $urandom_range(17)),
             8'(8'h30 + $urandom_range(9)), 8'(8'h30 + $urandom_range(9))};
    end else begin
      loc = $urandom;
    end
    return encode_item(call, loc, 7'($urandom));
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input wspr_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = {1'b0, it.idx, it.pwr, it.loc, it.call};
    in_user  = it.op;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.accept_item(it);
    @(negedge clk_i);
  endtask

  task automatic run_random(input int unsigned idle, input int unsigned stall);
    int unsigned roll;
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int n = 0; n < ItemsPerPhase; n++) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        send_item(random_encode(roll < 3));
      end else if ($urandom_range(9) == 0) begin
        send_item(tone_item(8'($urandom_range(255, NumSymbols))));
      end else begin
        send_item(tone_item(8'($urandom_range(NumSymbols - 1))));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reads of the reset store give the sync bit alone; out-of-range gives 0
    send_item(tone_item(8'd0));
    send_item(tone_item(8'd161));
    send_item(tone_item(8'd162));
    send_item(tone_item(8'd255));
    // extreme messages, power at both ends
    send_item(encode_item("      ", 32'h0000_0000, 7'h40));
    send_item(tone_item(8'd0));
    send_item(tone_item(8'd161));
    send_item(encode_item("ZZZZZZ", 32'hFFFF_FFFF, 7'h3F));
    send_item(tone_item(8'd5));
    send_item(encode_item("999999", "AA00", 7'd0));
    send_item(encode_item("K1ABC ", "FN42", 7'd37));
    send_item(tone_item(8'd100));
    // a bad byte in each callsign position, store must keep the last message
    send_item(encode_item("/1ABC ", "FN42", 7'd10));
    send_item(encode_item("K:ABC ", "FN42", 7'd10));
    send_item(encode_item("K1@BC ", "FN42", 7'd10));
    send_item(encode_item("K1A[C ", "FN42", 7'd10));
    send_item(encode_item({32'h4B314142, 8'h00, 8'h20}, "FN42", 7'd10));
    send_item(encode_item({40'h4B31414243, 8'hFF}, "FN42", 7'd10));
    send_item(tone_item(8'd1));
    send_item(tone_item(8'd100));
    send_item(encode_item("A9ZZ0 ", "RR99", 7'h7F));
    send_item(tone_item(8'd80));

    run_random(0, 0);
    run_random(83, 0);
    // hold off until the block has drained
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    run_random(0, 83);
    run_random(27, 27);

    in_valid = 1'b0;
    stall_pct = 0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
